FILE: sv/muscl_slope_limiter_macros.svh
// Assertion macros shared by the slope limiter RTL.
// No dependencies; included by the files that check their own logic.
`ifndef MUSCL_SLOPE_LIMITER_MACROS_SVH
`define MUSCL_SLOPE_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSL_ASSERT_IMPLY(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MSL_ASSERT_NEXT(name, clock, resetn, ante, cons, msg) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/msl_pkg.sv
// Types and constants of the MUSCL slope limiter.
// No dependencies; used by the interfaces and every module of the block.
`default_nettype none

package msl_pkg;

    localparam int SLOPE_W    = 32;
    localparam int DIFF_W     = SLOPE_W + 1;
    localparam int OMEGA_W    = 16;
    localparam int OMEGA_ONE  = 16384;
    localparam int TOL_W      = 16;
    localparam int IDX_W      = 2;
    localparam int COEF_W     = 16;
    localparam int PSLOPE_W   = DIFF_W + COEF_W + 1;
    localparam int DNUM_W     = PSLOPE_W + 1;
    localparam int SLOPE_SHIFT = 15;
    localparam int DMAG_W     = 33;
    localparam int NORM_BITS  = 22;
    localparam int SHIFT_W    = 4;
    localparam int OP_W       = NORM_BITS;
    localparam int SUM_W      = OP_W + 1;
    localparam int WPROD_W    = COEF_W + OP_W;
    localparam int CAPDEN_W   = WPROD_W + 1;
    localparam int SQ_W       = 2 * OP_W;
    localparam int AAB_W      = OP_W + SUM_W;
    localparam int XI_FRAC    = 16;
    localparam int NUM_W      = 61;
    localparam int DEN_W      = 45;
    localparam int QUO_W      = 18;
    localparam int CMP_W      = DEN_W + QUO_W;
    localparam int DIV_STAGES = QUO_W + 1;
    localparam int CAP_SHIFT  = 31;
    localparam int PM_W       = DMAG_W + QUO_W;
    localparam int PMSH_W     = PM_W - XI_FRAC;

    localparam logic [QUO_W-1:0] XI_TWO = QUO_W'(2) << XI_FRAC;

    typedef enum logic [1:0]
    {
        LIM_SUPERBEE,
        LIM_VAN_LEER,
        LIM_VAN_ALBADA,
        LIM_MINBEE
    } limiter_t;

    typedef enum logic [IDX_W-1:0]
    {
        REG_OMEGA     = 2'd0,
        REG_LIMITER   = 2'd1,
        REG_TOLERANCE = 2'd2
    } reg_index_t;

    typedef struct packed
    {
        logic signed [OMEGA_W-1:0] omega;
        limiter_t                  limiter;
        logic [TOL_W-1:0]          tol;
    } cfg_t;

    // Per-item data that travels beside the dividers.
    typedef struct packed
    {
        logic              opp;
        logic              use_cap;
        logic              dneg;
        logic [DMAG_W-1:0] dmag;
    } side_t;

endpackage

`default_nettype wire

FILE: sv/msl_in_if.sv
// Input channel of the slope limiter: three cell values per transfer.
// Depends on msl_pkg for the value width.
`default_nettype none

interface msl_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msl_pkg::SLOPE_W-1:0]    left_value;
    logic signed [msl_pkg::SLOPE_W-1:0]    centre_value;
    logic signed [msl_pkg::SLOPE_W-1:0]    right_value;

    modport source (output valid, left_value, centre_value, right_value, input ready);
    modport sink (input valid, left_value, centre_value, right_value, output ready);
endinterface

`default_nettype wire

FILE: sv/msl_out_if.sv
// Output channel of the slope limiter: one limited slope per transfer.
// Depends on msl_pkg for the value width.
`default_nettype none

interface msl_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msl_pkg::SLOPE_W-1:0]    limited_slope;

    modport source (output valid, limited_slope, input ready);
    modport sink (input valid, limited_slope, output ready);
endinterface

`default_nettype wire

FILE: sv/msl_cfg_if.sv
// Configuration write channel: register index and write data per transfer.
// Depends on msl_pkg for the index and data widths.
`default_nettype none

interface msl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [msl_pkg::IDX_W-1:0]     index;
    logic [msl_pkg::OMEGA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/muscl_slope_limiter.sv
// MUSCL slope limiter: one limited slope for each input transfer.
// Throughput one item per cycle while the output is not stalled; the two 19-stage dividers set the depth.
// The whole pipeline advances together and holds when the output is stalled.
// Reset clears the valid bits and loads omega 0, superbee and tolerance 1.
`default_nettype none
`include "muscl_slope_limiter_macros.svh"

module muscl_slope_limiter
(
    input  wire   clk,
    input  wire   rst_n,
    msl_in_if.sink    in_ch,
    msl_out_if.source out_ch,
    msl_cfg_if.sink   cfg
);
    import msl_pkg::*;

    // Configuration registers. The user must write them only while the block is idle;
    // the block itself does not enforce this. Every stage reads them directly.
    cfg_t cfg_reg;

    // One enable moves every stage. The output register frees when its
    // result is taken, so a new item enters on the same edge.
    logic ce;

    logic             f_valid;
    side_t            f_side;
    logic [NUM_W-1:0] num_main, num_cap;
    logic [DEN_W-1:0] den_main, den_cap;
    logic [QUO_W-1:0] q_main, q_cap;

    // Side data delayed to line up with the divider outputs.
    logic  line_valid_reg [0:DIV_STAGES-1];
    side_t line_reg [0:DIV_STAGES-1];

    // Limiter value stage.
    logic              x_valid_reg;
    logic [QUO_W-1:0]  xi_reg, xi_next, cap;
    logic              x_dneg_reg;
    logic [DMAG_W-1:0] x_dmag_reg;

    // Product stage.
    logic              m_valid_reg;
    logic              m_dneg_reg;
    logic [PM_W-1:0]   pm_reg;

    // Output register.
    logic                      out_valid_reg;
    logic signed [SLOPE_W-1:0] slope_reg, slope_next;
    logic [PMSH_W-1:0]         pm_sh;

    assign ce = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = ce;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.omega <= '0;
            cfg_reg.limiter <= LIM_SUPERBEE;
            cfg_reg.tol <= TOL_W'(1);
        end
        else if (cfg.valid)
        begin
            case (reg_index_t'(cfg.index))
                REG_OMEGA:     cfg_reg.omega <= cfg.data;
                REG_LIMITER:   cfg_reg.limiter <= limiter_t'(cfg.data[1:0]);
                REG_TOLERANCE: cfg_reg.tol <= cfg.data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Differences, weighted slope, normalisation and divider operands.
    msl_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ce           (ce),
        .in_valid     (in_ch.valid),
        .left_value   (in_ch.left_value),
        .centre_value (in_ch.centre_value),
        .right_value  (in_ch.right_value),
        .cfg          (cfg_reg),
        .out_valid    (f_valid),
        .side         (f_side),
        .num_main     (num_main),
        .den_main     (den_main),
        .num_cap      (num_cap),
        .den_cap      (den_cap)
    );

    // Quotient of the selected limiter.
    msl_divider u_div_main
    (
        .clk (clk),
        .ce  (ce),
        .num (num_main),
        .den (den_main),
        .quo (q_main)
    );

    // Quotient of the cap 2/(1-w+(1+w)r). A zero denominator saturates,
    // which the clamp to 2.0 below turns into the unbounded case.
    msl_divider u_div_cap
    (
        .clk (clk),
        .ce  (ce),
        .num (num_cap),
        .den (den_cap),
        .quo (q_cap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
                line_valid_reg[k] <= 1'b0;
            x_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            line_valid_reg[0] <= f_valid;
            for (int k = 1; k < DIV_STAGES; k++)
                line_valid_reg[k] <= line_valid_reg[k-1];
            x_valid_reg <= line_valid_reg[DIV_STAGES-1];
            m_valid_reg <= x_valid_reg;
            out_valid_reg <= m_valid_reg;
        end
    end

    // Differences of opposite sign give a zero limiter; otherwise the
    // quotient is clamped by the cap where the limiter calls for it.
    always_comb
    begin
        cap = (q_cap > XI_TWO) ? XI_TWO : q_cap;
        if (line_reg[DIV_STAGES-1].opp)
            xi_next = '0;
        else if (line_reg[DIV_STAGES-1].use_cap && (q_main > cap))
            xi_next = cap;
        else
            xi_next = q_main;
    end

    // Scale back by the limiter's fraction bits and saturate to 32 bits.
    always_comb
    begin
        pm_sh = pm_reg[PM_W-1:XI_FRAC];
        if (!m_dneg_reg)
        begin
            if (pm_sh > PMSH_W'({1'b0, {(SLOPE_W-1){1'b1}}}))
                slope_next = {1'b0, {(SLOPE_W-1){1'b1}}};
            else
                slope_next = SLOPE_W'(pm_sh);
        end
        else
        begin
            if (pm_sh > PMSH_W'({1'b1, {(SLOPE_W-1){1'b0}}}))
                slope_next = {1'b1, {(SLOPE_W-1){1'b0}}};
            else
                slope_next = SLOPE_W'(-pm_sh);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            line_reg[0] <= f_side;
            for (int k = 1; k < DIV_STAGES; k++)
                line_reg[k] <= line_reg[k-1];
            xi_reg <= xi_next;
            x_dneg_reg <= line_reg[DIV_STAGES-1].dneg;
            x_dmag_reg <= line_reg[DIV_STAGES-1].dmag;
            pm_reg <= x_dmag_reg * xi_reg;
            m_dneg_reg <= x_dneg_reg;
            slope_reg <= slope_next;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.limited_slope = slope_reg;

    `MSL_ASSERT_IMPLY(a_xi_bound, clk, rst_n, x_valid_reg, xi_reg <= XI_TWO, "limiter value above 2.0")
    `MSL_ASSERT_IMPLY(a_uncapped_bound, clk, rst_n, line_valid_reg[DIV_STAGES-1] && !line_reg[DIV_STAGES-1].opp && !line_reg[DIV_STAGES-1].use_cap, q_main <= XI_TWO, "uncapped quotient above 2.0")
    `MSL_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_ch.valid && !out_ch.ready, $stable(xi_reg) && $stable(pm_reg), "pipeline moved during a stall")

endmodule

`default_nettype wire

FILE: sv/msl_front.sv
// Front end of the slope limiter: differences, weighted slope, normalisation
// and divider operand selection over five register stages. Depends on msl_pkg.
`default_nettype none

module msl_front
(
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   ce,
    input  wire                                   in_valid,
    input  wire logic signed [msl_pkg::SLOPE_W-1:0] left_value,
    input  wire logic signed [msl_pkg::SLOPE_W-1:0] centre_value,
    input  wire logic signed [msl_pkg::SLOPE_W-1:0] right_value,
    input  wire msl_pkg::cfg_t                    cfg,
    output logic                                  out_valid,
    output msl_pkg::side_t                        side,
    output logic [msl_pkg::NUM_W-1:0]             num_main,
    output logic [msl_pkg::DEN_W-1:0]             den_main,
    output logic [msl_pkg::NUM_W-1:0]             num_cap,
    output logic [msl_pkg::DEN_W-1:0]             den_cap
);
    import msl_pkg::*;

    // Stage A: differences.
    logic                     a_valid_reg;
    logic signed [DIFF_W-1:0] dl_reg, dr_reg, dl_next, dr_next;

    // Stage B: slope products and difference magnitudes.
    logic                       b_valid_reg;
    logic signed [PSLOPE_W-1:0] pl_reg, pr_reg, pl_next, pr_next;
    logic [DIFF_W-1:0]          a0_reg, b0_reg, a0_next, b0_next;
    logic                       opp_reg;
    logic signed [OMEGA_W-1:0]  w_c;
    logic signed [COEF_W:0]     cp_s, cm_s;
    logic [COEF_W-1:0]          cp, cm;
    logic [DIFF_W-1:0]          dl_mag, dr_mag;
    logic [TOL_W-1:0]           tol_e;

    // Stage C: slope magnitude and normalised operands.
    logic                       c_valid_reg;
    side_t                      c_side_reg, c_side_next;
    logic [OP_W-1:0]            ca_reg, cb_reg, ca_next, cb_next;
    logic                       c_lt1_reg, c_lt2_reg;
    logic signed [DNUM_W-1:0]   dnum;
    logic [DNUM_W-1:0]          dnum_mag;
    logic [DIFF_W-1:0]          m;
    logic [5:0]                 len;
    logic [SHIFT_W-1:0]         s;

    // Stage D: products of the normalised operands.
    logic                       d_valid_reg;
    side_t                      d_side_reg;
    logic [OP_W-1:0]            da_reg, db_reg;
    logic [SUM_W-1:0]           dab_reg, ab_next;
    logic                       d_lt1_reg, d_lt2_reg;
    logic [WPROD_W-1:0]         wmb_reg, wpa_reg;
    logic [AAB_W-1:0]           aab_reg;
    logic [SQ_W-1:0]            aa_reg, bb_reg;

    // Stage E: divider operands.
    logic                       e_valid_reg;
    side_t                      e_side_reg, e_side_next;
    logic [NUM_W-1:0]           nm_reg, nc_reg, nm_next;
    logic [DEN_W-1:0]           dm_reg, dc_reg, dm_next;
    logic [CAPDEN_W-1:0]        cap_den;
    logic [DEN_W-1:0]           sq;

    always_comb
    begin
        dl_next = {centre_value[SLOPE_W-1], centre_value} - {left_value[SLOPE_W-1], left_value};
        dr_next = {right_value[SLOPE_W-1], right_value} - {centre_value[SLOPE_W-1], centre_value};
    end

    always_comb
    begin
        if (cfg.omega > OMEGA_W'(OMEGA_ONE))
            w_c = OMEGA_W'(OMEGA_ONE);
        else if (cfg.omega < -OMEGA_W'(OMEGA_ONE))
            w_c = -OMEGA_W'(OMEGA_ONE);
        else
            w_c = cfg.omega;
        cp_s = (COEF_W+1)'(OMEGA_ONE) + (COEF_W+1)'(w_c);
        cm_s = (COEF_W+1)'(OMEGA_ONE) - (COEF_W+1)'(w_c);
        cp = cp_s[COEF_W-1:0];
        cm = cm_s[COEF_W-1:0];
        pl_next = dl_reg * $signed({1'b0, cp});
        pr_next = dr_reg * $signed({1'b0, cm});
        tol_e = (cfg.tol == '0) ? TOL_W'(1) : cfg.tol;
        dl_mag = dl_reg[DIFF_W-1] ? DIFF_W'(-dl_reg) : DIFF_W'(dl_reg);
        dr_mag = dr_reg[DIFF_W-1] ? DIFF_W'(-dr_reg) : DIFF_W'(dr_reg);
        a0_next = (dl_mag < DIFF_W'(tol_e)) ? DIFF_W'(tol_e) : dl_mag;
        b0_next = (dr_mag < DIFF_W'(tol_e)) ? DIFF_W'(tol_e) : dr_mag;
    end

    // Shift both magnitudes right together until the larger is below 2^22.
    always_comb
    begin
        dnum = DNUM_W'(pl_reg) + DNUM_W'(pr_reg);
        dnum_mag = dnum[DNUM_W-1] ? DNUM_W'(-dnum) : DNUM_W'(dnum);
        c_side_next.opp = opp_reg;
        c_side_next.use_cap = 1'b0;
        c_side_next.dneg = dnum[DNUM_W-1];
        c_side_next.dmag = dnum_mag[SLOPE_SHIFT +: DMAG_W];
        m = (a0_reg > b0_reg) ? a0_reg : b0_reg;
        len = '0;
        for (int k = 0; k < DIFF_W; k++)
        begin
            if (m[k])
                len = 6'(k + 1);
        end
        s = (len > 6'(NORM_BITS)) ? SHIFT_W'(len - 6'(NORM_BITS)) : '0;
        ca_next = OP_W'(a0_reg >> s);
        cb_next = OP_W'(b0_reg >> s);
        if (cb_next == '0)
            cb_next = OP_W'(1);
    end

    always_comb
    begin
        ab_next = SUM_W'(ca_reg) + SUM_W'(cb_reg);
    end

    always_comb
    begin
        cap_den = CAPDEN_W'(wmb_reg) + CAPDEN_W'(wpa_reg);
        sq = DEN_W'(aa_reg) + DEN_W'(bb_reg);
        e_side_next = d_side_reg;
        case (cfg.limiter)
            LIM_SUPERBEE:
            begin
                if (d_lt2_reg)
                begin
                    nm_next = NUM_W'(da_reg) << (XI_FRAC + 1);
                    dm_next = DEN_W'(db_reg);
                    e_side_next.use_cap = 1'b0;
                end
                else if (d_lt1_reg)
                begin
                    nm_next = NUM_W'(1) << XI_FRAC;
                    dm_next = DEN_W'(1);
                    e_side_next.use_cap = 1'b0;
                end
                else
                begin
                    nm_next = NUM_W'(da_reg) << XI_FRAC;
                    dm_next = DEN_W'(db_reg);
                    e_side_next.use_cap = 1'b1;
                end
            end
            LIM_VAN_LEER:
            begin
                nm_next = NUM_W'(da_reg) << (XI_FRAC + 1);
                dm_next = DEN_W'(dab_reg);
                e_side_next.use_cap = 1'b1;
            end
            LIM_VAN_ALBADA:
            begin
                nm_next = NUM_W'(aab_reg) << XI_FRAC;
                dm_next = sq;
                e_side_next.use_cap = 1'b1;
            end
            LIM_MINBEE:
            begin
                if (d_lt1_reg)
                begin
                    nm_next = NUM_W'(da_reg) << XI_FRAC;
                    dm_next = DEN_W'(db_reg);
                    e_side_next.use_cap = 1'b0;
                end
                else
                begin
                    nm_next = NUM_W'(1) << XI_FRAC;
                    dm_next = DEN_W'(1);
                    e_side_next.use_cap = 1'b1;
                end
            end
            default:
            begin
                nm_next = '0;
                dm_next = DEN_W'(1);
                e_side_next.use_cap = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            dl_reg <= dl_next;
            dr_reg <= dr_next;

            pl_reg <= pl_next;
            pr_reg <= pr_next;
            a0_reg <= a0_next;
            b0_reg <= b0_next;
            opp_reg <= dl_reg[DIFF_W-1] ^ dr_reg[DIFF_W-1];

            c_side_reg <= c_side_next;
            ca_reg <= ca_next;
            cb_reg <= cb_next;
            c_lt1_reg <= a0_reg < b0_reg;
            c_lt2_reg <= {a0_reg, 1'b0} < {1'b0, b0_reg};

            d_side_reg <= c_side_reg;
            da_reg <= ca_reg;
            db_reg <= cb_reg;
            dab_reg <= ab_next;
            d_lt1_reg <= c_lt1_reg;
            d_lt2_reg <= c_lt2_reg;
            wmb_reg <= cm * cb_reg;
            wpa_reg <= cp * ca_reg;
            aab_reg <= ca_reg * ab_next;
            aa_reg <= ca_reg * ca_reg;
            bb_reg <= cb_reg * cb_reg;

            e_side_reg <= e_side_next;
            nm_reg <= nm_next;
            dm_reg <= dm_next;
            nc_reg <= NUM_W'(db_reg) << CAP_SHIFT;
            dc_reg <= DEN_W'(cap_den);
        end
    end

    assign out_valid = e_valid_reg;
    assign side = e_side_reg;
    assign num_main = nm_reg;
    assign den_main = dm_reg;
    assign num_cap = nc_reg;
    assign den_cap = dc_reg;

endmodule

`default_nettype wire

FILE: sv/msl_divider.sv
// Pipelined restoring divider, one quotient bit per stage, quotient saturated.
// Depends on msl_pkg for the operand and quotient widths.
`default_nettype none

module msl_divider
(
    input  wire                          clk,
    input  wire                          ce,
    input  wire [msl_pkg::NUM_W-1:0]     num,
    input  wire [msl_pkg::DEN_W-1:0]     den,
    output logic [msl_pkg::QUO_W-1:0]    quo
);
    import msl_pkg::*;

    typedef struct packed
    {
        logic             sat;
        logic [NUM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_stage_t;

    div_stage_t stage_reg [0:QUO_W];
    div_stage_t stage_next [0:QUO_W];

    // First stage flags a quotient that does not fit; a zero divisor lands here too.
    always_comb
    begin
        stage_next[0].sat = CMP_W'(num) >= {den, QUO_W'(0)};
        stage_next[0].rem = num;
        stage_next[0].den = den;
        stage_next[0].quo = '0;
    end

    for (genvar k = 1; k <= QUO_W; k++)
    begin : g_bit
        localparam int BIT = QUO_W - k;
        logic [CMP_W-1:0] trial;
        logic             fits;

        always_comb
        begin
            trial = CMP_W'(stage_reg[k-1].den) << BIT;
            fits = !stage_reg[k-1].sat && (CMP_W'(stage_reg[k-1].rem) >= trial);
            stage_next[k] = stage_reg[k-1];
            if (fits)
            begin
                stage_next[k].rem = NUM_W'(CMP_W'(stage_reg[k-1].rem) - trial);
                stage_next[k].quo[BIT] = 1'b1;
            end
        end
    end

    for (genvar k = 0; k <= QUO_W; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (ce)
                stage_reg[k] <= stage_next[k];
        end
    end

    assign quo = stage_reg[QUO_W].sat ? '1 : stage_reg[QUO_W].quo;

endmodule

`default_nettype wire

FILE: tb/muscl_slope_limiter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the MUSCL slope limiter: watches the input, output and
// configuration channels, predicts each limited slope and compares it.
// Depends on msl_pkg and the three channel interfaces.

module muscl_slope_limiter_checker
    import msl_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    msl_in_if    in_ch,
    msl_out_if   out_ch,
    msl_cfg_if   cfg,
    output int   errors,
    output int   pending
);

    longint          omega_reg;
    limiter_t        limiter_reg;
    longint unsigned tol_reg;
    logic [SLOPE_W-1:0] slope_q[$];

    function automatic longint unsigned magnitude(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint unsigned min_u(longint unsigned p, longint unsigned q);
        return (p < q) ? p : q;
    endfunction

    // Cap 2/(1-w+(1+w)r) with r = a/b, sixteen fraction bits, at most 2.0.
    function automatic longint unsigned cap_of(longint unsigned a, longint unsigned b,
                                               longint w);
        longint unsigned two;
        longint unsigned den;
        two = 64'd2 << XI_FRAC;
        den = longint'(OMEGA_ONE - w) * b + longint'(OMEGA_ONE + w) * a;
        if (den == 0)
            return two;
        return min_u(((64'd2 * OMEGA_ONE * b) << XI_FRAC) / den, two);
    endfunction

    function automatic longint unsigned limiter_xi(longint unsigned a0,
                                                   longint unsigned b0,
                                                   longint w, limiter_t sel);
        longint unsigned one;
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        int s;
        one = 64'd1 << XI_FRAC;
        m = (a0 > b0) ? a0 : b0;
        s = 0;
        while ((m >> s) >= (64'd1 << NORM_BITS))
            s++;
        a = a0 >> s;
        b = b0 >> s;
        if (b == 0)
            b = 1;
        case (sel)
            LIM_SUPERBEE:
            begin
                if (2 * a0 < b0)
                    return ((2 * a) << XI_FRAC) / b;
                if (a0 < b0)
                    return one;
                return min_u((a << XI_FRAC) / b, cap_of(a, b, w));
            end
            LIM_VAN_LEER:
                return min_u(((2 * a) << XI_FRAC) / (a + b), cap_of(a, b, w));
            LIM_VAN_ALBADA:
                return min_u(((a * (a + b)) << XI_FRAC) / (a * a + b * b),
                             cap_of(a, b, w));
            default:
            begin
                if (a0 < b0)
                    return (a << XI_FRAC) / b;
                return min_u(one, cap_of(a, b, w));
            end
        endcase
    endfunction

    function automatic logic [SLOPE_W-1:0] predict_slope(logic signed [SLOPE_W-1:0] l,
                                                         logic signed [SLOPE_W-1:0] c,
                                                         logic signed [SLOPE_W-1:0] r);
        longint w;
        longint dl;
        longint dr;
        longint dnum;
        longint res;
        longint unsigned dmag;
        longint unsigned a;
        longint unsigned b;
        longint unsigned xi;
        longint unsigned tol;
        w = omega_reg;
        if (w > OMEGA_ONE)
            w = OMEGA_ONE;
        if (w < -OMEGA_ONE)
            w = -OMEGA_ONE;
        tol = (tol_reg == 0) ? 1 : tol_reg;
        dl = longint'(c) - longint'(l);
        dr = longint'(r) - longint'(c);
        dnum = (OMEGA_ONE + w) * dl + (OMEGA_ONE - w) * dr;
        dmag = magnitude(dnum) >> SLOPE_SHIFT;
        a = magnitude(dl);
        b = magnitude(dr);
        if (a < tol)
            a = tol;
        if (b < tol)
            b = tol;
        // Differences of opposite sign mean an extremum: the slope is flattened.
        if ((dl < 0) != (dr < 0))
            xi = 0;
        else
            xi = limiter_xi(a, b, w, limiter_reg);
        res = longint'((dmag * xi) >> XI_FRAC);
        if (dnum < 0)
            res = -res;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        return res[SLOPE_W-1:0];
    endfunction

    assign pending = slope_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            omega_reg   <= 0;
            limiter_reg <= LIM_SUPERBEE;
            tol_reg     <= 1;
            errors      <= 0;
            slope_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_OMEGA)
                    omega_reg <= longint'($signed(cfg.data));
                else if (cfg.index == REG_LIMITER)
                    limiter_reg <= limiter_t'(cfg.data[1:0]);
                else if (cfg.index == REG_TOLERANCE)
                    tol_reg <= cfg.data;
            end
            if (in_ch.valid && in_ch.ready)
                slope_q.push_back(predict_slope(in_ch.left_value, in_ch.centre_value,
                                                in_ch.right_value));
            if (out_ch.valid && out_ch.ready)
            begin
                if (slope_q.size() == 0)
                begin
                    $error("limited_slope: unexpected transfer, actual %0d",
                           $signed(out_ch.limited_slope));
                    errors <= errors + 1;
                end
                else
                begin
                    if (out_ch.limited_slope !== slope_q[0])
                    begin
                        $error("limited_slope: expected %0d, actual %0d",
                               $signed(slope_q[0]), $signed(out_ch.limited_slope));
                        errors <= errors + 1;
                    end
                    void'(slope_q.pop_front());
                end
            end
        end
    end

endmodule

FILE: tb/muscl_slope_limiter_tb.sv
`timescale 1ns / 1ps
// Top of the slope limiter testbench: clock, reset, stimulus and verdict.
// Depends on msl_pkg, the channel interfaces, the checker and the block.

module muscl_slope_limiter_tb;
    import msl_pkg::*;

    // The pipeline is 27 deep; allow comfortably more before a register write.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 300000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;

    msl_in_if  in_ch();
    msl_out_if out_ch();
    msl_cfg_if cfg();

    muscl_slope_limiter DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    muscl_slope_limiter_checker checker_i
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .cfg     (cfg),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cycle counter: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("muscl_slope_limiter regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 5);
    endfunction

    // Receiver. Early in the run it holds off for a long stretch while the
    // sender keeps offering, so the pipeline fills and the input is stalled.
    // After that the ready line alternates between random high and low runs.
    initial
    begin
        int hold;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        out_ch.ready <= 1'b1;
        repeat (120) @(negedge clk);
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 200; hold++)
            @(negedge clk);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(40, 1)) @(negedge clk);
            hold = gap_len();
            if (hold > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
        end
    end

    // Offers one cell triple; called at a falling edge and returns at one.
    // Valid stays high across back-to-back transfers.
    task automatic send_cells(logic [31:0] l, logic [31:0] c, logic [31:0] r);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.left_value   <= l;
        in_ch.centre_value <= c;
        in_ch.right_value  <= r;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        gap = gap_len();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic write_reg(reg_index_t idx, logic [15:0] value);
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_config(logic [15:0] omega, limiter_t lim, logic [15:0] tol);
        write_reg(REG_OMEGA, omega);
        write_reg(REG_LIMITER, 16'(lim));
        write_reg(REG_TOLERANCE, tol);
    endtask

    // A neighbour offset from the centre: tiny, moderate, huge or any value.
    function automatic logic [31:0] offset_value(logic [31:0] c);
        int pick;
        logic [31:0] delta;
        pick = $urandom_range(99);
        if (pick < 30)
            delta = $urandom_range(64);
        else if (pick < 65)
            delta = $urandom_range(32'h0040_0000);
        else if (pick < 85)
            delta = $urandom & 32'h0FFF_FFFF;
        else
            return $urandom;
        return ($urandom_range(1) != 0) ? c + delta : c - delta;
    endfunction

    task automatic random_items(int count);
        logic [31:0] c;
        repeat (count)
        begin
            c = $urandom;
            if ($urandom_range(3) == 0)
                c = c >>> $urandom_range(31);
            send_cells(offset_value(c), c, offset_value(c));
        end
    endtask

    initial
    begin
        logic [31:0] directed[20][3];
        int k;
        directed = '{
            '{32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF},
            '{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
            '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
            '{32'h0001_0000, 32'h0001_0000, 32'h0003_0000},
            '{32'h0000_0000, 32'h0001_0000, 32'h0003_0000},
            '{32'h0000_0000, 32'h0002_0000, 32'h0004_0000},
            '{32'h0000_0000, 32'h0004_0000, 32'h0006_0000},
            '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000},
            '{32'h0004_0000, 32'h0002_0000, 32'h0000_0000},
            '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002},
            '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF},
            '{32'hFFFF_0000, 32'h0000_0000, 32'h0000_0100},
            '{32'h1234_5678, 32'h2345_6789, 32'h3456_789A},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
            '{32'h0000_0000, 32'h0000_8000, 32'h7FFF_FFFF},
            '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
            '{32'h0000_0000, 32'h0000_0003, 32'h0000_0004}
        };
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.left_value   = '0;
        in_ch.centre_value = '0;
        in_ch.right_value  = '0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_OMEGA;
        cfg.data           = '0;
        // Reset is released at a falling edge, clear of the active edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first, with the directed cases, then each other limiter through
        // both case lists under extreme weights and tolerances, then superbee on random cases.
        for (k = 0; k < 20; k++)
            send_cells(directed[k][0], directed[k][1], directed[k][2]);
        random_items(50);

        set_config(16'sd16384, LIM_VAN_LEER, 16'd0);
        for (k = 0; k < 20; k++)
            send_cells(directed[k][0], directed[k][1], directed[k][2]);
        random_items(50);

        set_config(-16'sd16384, LIM_VAN_ALBADA, 16'd65535);
        for (k = 0; k < 20; k++)
            send_cells(directed[k][0], directed[k][1], directed[k][2]);
        random_items(50);

        set_config(16'h8000, LIM_MINBEE, 16'd1);
        for (k = 0; k < 20; k++)
            send_cells(directed[k][0], directed[k][1], directed[k][2]);
        random_items(50);

        set_config(16'h7FFF, LIM_SUPERBEE, 16'd300);
        random_items(50);

        // Random settings across the legal range and beyond it.
        repeat (5)
        begin
            set_config($urandom_range(1) != 0 ? 16'($urandom) :
                                                16'($urandom_range(32768) - 16384),
                       limiter_t'(2'($urandom_range(3))), 16'($urandom));
            random_items(40);
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("muscl_slope_limiter regression: pass");
        else
            $display("muscl_slope_limiter regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/msl_pkg.sv
sv/msl_in_if.sv
sv/msl_out_if.sv
sv/msl_cfg_if.sv
sv/msl_front.sv
sv/msl_divider.sv
sv/muscl_slope_limiter.sv
tb/muscl_slope_limiter_checker.sv
tb/muscl_slope_limiter_tb.sv
